>>> hdl/gpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpm_pkg: shared types and constants of the glob pattern matcher
// Item layouts, action codes, pattern metacharacters, state encodings and
// the control structs between the command sequencer and the scan unit.
// ----------------------------------------------------------------------------
package gpm_pkg;

    // Action codes of an input item
    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_APPEND  = 2'd1,
        ACT_SUBJECT = 2'd2,
        ACT_END     = 2'd3
    } gpm_action_t;

    // Input item
    typedef struct packed {
        gpm_action_t action;
        logic [7:0]  data_byte;
    } gpm_in_t;

    // Result item
    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } gpm_out_t;

    // Pattern metacharacters
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_ANY   = 8'h3F;
    localparam logic [7:0] CH_ESC   = 8'h5C;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Command sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOSE_GO,
        ST_CLOSE_RUN,
        ST_ADV_GO,
        ST_ADV_RUN,
        ST_REPORT
    } gpm_state_t;

    // Scan unit states
    typedef enum logic [1:0] {
        SC_IDLE,
        SC_PREP,
        SC_RUN,
        SC_FIN
    } gpm_scan_state_t;

    // Token parser mode inside a scan
    typedef enum logic [1:0] {
        TK_PLAIN,
        TK_ESC_ARG,
        TK_LIST
    } gpm_tok_mode_t;

    // Sequencer to scan unit
    typedef struct packed {
        logic start;
        logic advance;   // 1: step on subject byte, 0: star closure of start set
    } gpm_scan_cmd_t;

    // Scan unit to sequencer
    typedef struct packed {
        logic done;
        logic live_end;  // live bit at the pattern end position
    } gpm_scan_sts_t;

endpackage

>>> hdl/gpm_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpm_store: pattern byte memory
// One write port for pattern appends, one registered read port for the scan.
// ----------------------------------------------------------------------------
module gpm_store #(
    parameter int MAX_PATTERN = 32,
    localparam int PW = $clog2(MAX_PATTERN)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [PW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [PW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [MAX_PATTERN];

    // Write on append; the read is registered, so the address is given ahead of use
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/gpm_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpm_scan: iterative live-position scan unit
// Walks the stored pattern one byte per cycle, parsing tokens on the fly,
// and builds the next set of live positions with star closure folded in.
// ----------------------------------------------------------------------------
module gpm_scan #(
    parameter int MAX_PATTERN = 32,
    localparam int PW = $clog2(MAX_PATTERN),
    localparam int LW = $clog2(MAX_PATTERN + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  gpm_pkg::gpm_scan_cmd_t scan_cmd,
    input  logic [LW-1:0]          pat_len,
    input  logic [7:0]             subj_byte,
    output logic [PW-1:0]          rd_addr,
    input  logic [7:0]             rd_data,
    output gpm_pkg::gpm_scan_sts_t scan_sts
);
    import gpm_pkg::*;

    gpm_scan_state_t state_reg, state_next;
    gpm_tok_mode_t   mode_reg, mode_next;
    logic [PW-1:0]   pos_reg;
    logic            adv_reg;
    logic            arm_reg, arm_next;
    logic            hit_reg, hit_next;
    logic [MAX_PATTERN:0] set_reg, set_next;
    logic [MAX_PATTERN:0] live_reg;

    logic [LW-1:0] pos_ext;
    logic [LW-1:0] pos_inc;
    logic          last_pos;
    logic          live_p;
    logic          here_p;
    logic          byte_eq;

    assign pos_ext  = LW'(pos_reg);
    assign pos_inc  = pos_ext + LW'(1);
    assign last_pos = (pos_inc == pat_len);
    assign live_p   = adv_reg & live_reg[pos_ext];
    assign here_p   = set_reg[pos_ext];
    assign byte_eq  = (rd_data == subj_byte);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SC_IDLE: begin
                if (scan_cmd.start) begin
                    state_next = SC_PREP;
                end
            end
            SC_PREP: begin
                state_next = (pat_len == '0) ? SC_FIN : SC_RUN;
            end
            SC_RUN: begin
                if (last_pos) begin
                    state_next = SC_FIN;
                end
            end
            SC_FIN: begin
                state_next = SC_IDLE;
            end
            default: state_next = SC_IDLE;
        endcase
    end

    // Outputs: prefetch address and status
    always_comb begin
        rd_addr           = (state_reg == SC_RUN) ? pos_reg + PW'(1) : '0;
        scan_sts.done     = (state_reg == SC_FIN);
        scan_sts.live_end = live_reg[pat_len];
    end

    // Step one pattern byte: token parse and next-set update
    always_comb begin
        set_next  = set_reg;
        mode_next = mode_reg;
        arm_next  = arm_reg;
        hit_next  = hit_reg;
        unique case (mode_reg)
            TK_PLAIN: begin
                case (rd_data)
                    CH_STAR: begin
                        if (live_p) begin
                            set_next[pos_ext] = 1'b1;
                        end
                        if (live_p || here_p) begin
                            set_next[pos_inc] = 1'b1;
                        end
                    end
                    CH_ANY: begin
                        if (live_p) begin
                            set_next[pos_inc] = 1'b1;
                        end
                    end
                    CH_ESC: begin
                        mode_next = TK_ESC_ARG;
                        arm_next  = live_p;
                    end
                    CH_OPEN: begin
                        mode_next = TK_LIST;
                        arm_next  = live_p;
                        hit_next  = 1'b0;
                    end
                    default: begin
                        if (live_p && byte_eq) begin
                            set_next[pos_inc] = 1'b1;
                        end
                    end
                endcase
            end
            TK_ESC_ARG: begin
                if (arm_reg && byte_eq) begin
                    set_next[pos_inc] = 1'b1;
                end
                mode_next = TK_PLAIN;
            end
            TK_LIST: begin
                if (rd_data == CH_CLOSE) begin
                    if (arm_reg && hit_reg) begin
                        set_next[pos_inc] = 1'b1;
                    end
                    mode_next = TK_PLAIN;
                end else if (byte_eq) begin
                    hit_next = 1'b1;
                end
            end
            default: mode_next = TK_PLAIN;
        endcase
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            mode_reg  <= TK_PLAIN;
            live_reg  <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                SC_IDLE: begin
                    if (scan_cmd.start) begin
                        adv_reg <= scan_cmd.advance;
                    end
                end
                SC_PREP: begin
                    // Closure pass seeds position zero, step pass starts empty
                    pos_reg  <= '0;
                    mode_reg <= TK_PLAIN;
                    arm_reg  <= 1'b0;
                    hit_reg  <= 1'b0;
                    set_reg  <= {{MAX_PATTERN{1'b0}}, ~adv_reg};
                end
                SC_RUN: begin
                    pos_reg  <= pos_reg + PW'(1);
                    mode_reg <= mode_next;
                    arm_reg  <= arm_next;
                    hit_reg  <= hit_next;
                    set_reg  <= set_next;
                end
                SC_FIN: begin
                    live_reg <= set_reg;
                end
                default: ;
            endcase
        end
    end

endmodule

>>> hdl/glob_pattern_matcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glob_pattern_matcher_core: glob pattern matcher, top level
// Loads a glob pattern byte by byte and matches subject strings against it.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries items of action and data_byte. Clear and append items
//   run no scan. A subject byte runs one scan of the stored pattern; the
//   first byte of a subject first runs a closure pass that builds the start
//   set. An end-of-subject item goes straight to the result when a subject
//   is in progress, runs the closure pass first otherwise, and gives one
//   result item on the m_ channel with matched and pattern_overflow.
//   Per subject byte the scan unit visits one stored pattern byte per cycle
//   through the single memory read port.
//   s_ready is high only while no item is in work.
//   The result sits in an output register; while the receiver stalls, the
//   block keeps taking items until a second result is due, and then holds
//   that item until the first result is taken.
//   Reset empties the pattern and clears overflow and subject state; the
//   pattern memory is not cleared, only bytes below the pattern length count.
// ----------------------------------------------------------------------------
module glob_pattern_matcher_core #(
    parameter int MAX_PATTERN = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  gpm_pkg::gpm_in_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output gpm_pkg::gpm_out_t m_data
);
    import gpm_pkg::*;

    localparam int PW = $clog2(MAX_PATTERN);
    localparam int LW = $clog2(MAX_PATTERN + 1);

    gpm_state_t    state_reg, state_next;
    logic [LW-1:0] len_reg;
    logic          ovf_reg;
    logic          started_reg;
    gpm_action_t   act_reg;
    logic [7:0]    byte_reg;
    logic          m_valid_reg;
    gpm_out_t      m_data_reg;

    gpm_scan_cmd_t scan_cmd;
    gpm_scan_sts_t scan_sts;
    logic [PW-1:0] rd_addr;
    logic [7:0]    rd_data;

    logic s_fire;
    logic nz_byte;
    logic store_full;
    logic wr_en;
    logic out_free;

    assign s_fire     = s_valid && s_ready;
    assign nz_byte    = (s_data.data_byte != CH_NUL);
    assign store_full = (len_reg == LW'(MAX_PATTERN));
    assign wr_en      = s_fire && (s_data.action == ACT_APPEND) && nz_byte && !store_full;
    assign out_free   = !m_valid_reg || m_ready;

    gpm_store #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (len_reg[PW-1:0]),
        .wr_data (s_data.data_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gpm_scan #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .scan_cmd  (scan_cmd),
        .pat_len   (len_reg),
        .subj_byte (byte_reg),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .scan_sts  (scan_sts)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (s_data.action)
                        ACT_SUBJECT: begin
                            if (nz_byte) begin
                                state_next = started_reg ? ST_ADV_GO : ST_CLOSE_GO;
                            end
                        end
                        ACT_END: begin
                            state_next = started_reg ? ST_REPORT : ST_CLOSE_GO;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLOSE_GO: state_next = ST_CLOSE_RUN;
            ST_CLOSE_RUN: begin
                if (scan_sts.done) begin
                    state_next = (act_reg == ACT_SUBJECT) ? ST_ADV_GO : ST_REPORT;
                end
            end
            ST_ADV_GO: state_next = ST_ADV_RUN;
            ST_ADV_RUN: begin
                if (scan_sts.done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_REPORT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready          = (state_reg == ST_IDLE);
        scan_cmd.start   = (state_reg == ST_CLOSE_GO) || (state_reg == ST_ADV_GO);
        scan_cmd.advance = (state_reg == ST_ADV_GO);
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Capture the item and keep pattern, subject and result state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (s_fire) begin
                act_reg  <= s_data.action;
                byte_reg <= s_data.data_byte;
                unique case (s_data.action)
                    ACT_CLEAR: begin
                        len_reg     <= '0;
                        ovf_reg     <= 1'b0;
                        started_reg <= 1'b0;
                    end
                    ACT_APPEND: begin
                        if (nz_byte) begin
                            started_reg <= 1'b0;
                            if (store_full) begin
                                ovf_reg <= 1'b1;
                            end else begin
                                len_reg <= len_reg + LW'(1);
                            end
                        end
                    end
                    default: ;
                endcase
            end

            // A finished closure pass opens the subject
            if (state_reg == ST_CLOSE_RUN && scan_sts.done) begin
                started_reg <= 1'b1;
            end

            // Load a new result, else drop a taken one
            if (state_reg == ST_REPORT && out_free) begin
                m_valid_reg                 <= 1'b1;
                m_data_reg.matched          <= !ovf_reg && scan_sts.live_end;
                m_data_reg.pattern_overflow <= ovf_reg;
                started_reg                 <= 1'b0;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> hdl/gpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpm_checker: port-level checks of the glob pattern matcher
// Watches the top level's channels and flags protocol or result slips.
// ----------------------------------------------------------------------------
module gpm_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input gpm_pkg::gpm_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input gpm_pkg::gpm_out_t m_data
);
    import gpm_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // Overflow forces no match
    a_ovf_nomatch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.matched && m_data.pattern_overflow))
        else $error("match reported with pattern overflow");

    // An end-of-subject item always takes the block busy
    a_end_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == ACT_END |=> !s_ready)
        else $error("ready right after end of subject");

    // A clear item leaves the block ready on the following cycle
    a_clear_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action == ACT_CLEAR |=> s_ready)
        else $error("not ready after clear");

    // Reset empties the result register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind glob_pattern_matcher_core gpm_checker u_gpm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
